// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers used by source_token_scanner
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ----- design/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// sts_pkg
// types, token codes and character constants of the source token scanner
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int POSITION_WIDTH = 20;
   localparam int LINE_WIDTH     = 16;
   localparam int KEYWORD_MAX    = 6;
   localparam int KEYWORD_LEN    = 6;
   localparam int KEYWORD_COUNT  = 3;
   localparam int QUEUE_DEPTH    = 4;

   typedef logic [3:0] kind_type;

   localparam kind_type KIND_IDENT     = 4'd0;
   localparam kind_type KIND_EXPORT    = 4'd1;
   localparam kind_type KIND_IMPORT    = 4'd2;
   localparam kind_type KIND_RETURN    = 4'd3;
   localparam kind_type KIND_NUMBER    = 4'd4;
   localparam kind_type KIND_STRING    = 4'd5;
   localparam kind_type KIND_LPAREN    = 4'd6;
   localparam kind_type KIND_RPAREN    = 4'd7;
   localparam kind_type KIND_LBRACE    = 4'd8;
   localparam kind_type KIND_RBRACE    = 4'd9;
   localparam kind_type KIND_COMMA     = 4'd10;
   localparam kind_type KIND_SEMICOLON = 4'd11;
   localparam kind_type KIND_DOT       = 4'd12;
   localparam kind_type KIND_END       = 4'd13;
   localparam kind_type KIND_UNTERM    = 4'd14;
   localparam kind_type KIND_UNEXPECT  = 4'd15;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0a;
   localparam logic [7:0] CHAR_CR        = 8'h0d;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_COMMA     = 8'h2c;
   localparam logic [7:0] CHAR_DOT       = 8'h2e;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3b;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7b;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7d;

   localparam logic [7:0] KEYWORD_TABLE [KEYWORD_COUNT][KEYWORD_LEN] = '{
      '{"e", "x", "p", "o", "r", "t"},
      '{"i", "m", "p", "o", "r", "t"},
      '{"r", "e", "t", "u", "r", "n"}
   };

   localparam kind_type KEYWORD_KIND [KEYWORD_COUNT] = '{
      KIND_EXPORT, KIND_IMPORT, KIND_RETURN
   };

   typedef struct packed {
      kind_type                  kind;
      logic [POSITION_WIDTH-1:0] start;
      logic [POSITION_WIDTH-1:0] length;
      logic [LINE_WIDTH-1:0]     line;
      logic [LINE_WIDTH-1:0]     column;
   } token_type;

   // one queue entry holds every token caused by one input byte
   typedef struct packed {
      logic      pair;
      token_type first;
      token_type second;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ----- design/sts_channels.sv -----
// ----------------------------------------------------------------------------
// sts_channels
// valid/ready channel interfaces for source bytes and tokens
// ----------------------------------------------------------------------------
interface sts_req_if;
   import sts_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] source_byte;

   modport source (output valid, output source_byte, input ready);
   modport sink (input valid, input source_byte, output ready);
endinterface

interface sts_rsp_if;
   import sts_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [3:0]                token_kind;
   logic [POSITION_WIDTH-1:0] token_start;
   logic [POSITION_WIDTH-1:0] token_length;
   logic [LINE_WIDTH-1:0]     token_line;
   logic [LINE_WIDTH-1:0]     token_column;
   logic                      last_of_run;

   modport source (
      output valid, output token_kind, output token_start, output token_length,
      output token_line, output token_column, output last_of_run, input ready
   );
   modport sink (
      input valid, input token_kind, input token_start, input token_length,
      input token_line, input token_column, input last_of_run, output ready
   );
endinterface

// ----- design/sts_front.sv -----
// ----------------------------------------------------------------------------
// sts_front
// accepts source bytes, tracks scan state and builds token entries
// ----------------------------------------------------------------------------
module sts_front (
   input  logic                      clock,
   input  logic                      reset,
   sts_req_if.sink                   req_bus,
   input  sts_pkg::queue_status_type q_status,
   output logic                      q_push,
   output sts_pkg::entry_type        q_entry
);
   import sts_pkg::*;

   localparam int BUF_IDX_W = $clog2(KEYWORD_MAX);
   localparam int WLEN_W    = $clog2(KEYWORD_MAX + 2);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_INT,
      MODE_FRAC,
      MODE_STR
   } mode_type;

   mode_type                  mode_ff, mode_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [POSITION_WIDTH-1:0] begin_ff, begin_in;
   logic [LINE_WIDTH-1:0]     line_ff, line_in;
   logic [LINE_WIDTH-1:0]     col_ff, col_in;
   logic [WLEN_W-1:0]         wlen_ff, wlen_in;
   logic [7:0]                buf_ff [KEYWORD_MAX];
   logic [7:0]                buf_in [KEYWORD_MAX];

   logic                      accept;
   logic [7:0]                c;
   logic                      is_alpha, is_digit;
   logic [POSITION_WIDTH-1:0] pos_inc;
   logic [LINE_WIDTH-1:0]     col_inc, line_inc;
   kind_type                  word_kind;
   logic                      run_idle, flush, idle_emit, str_close;
   token_type                 flush_tok, idle_tok;
   logic                      kw_hit [KEYWORD_COUNT];

   assign c        = req_bus.source_byte;
   assign req_bus.ready = !q_status.full;
   assign accept   = req_bus.valid && req_bus.ready;
   assign is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   assign is_digit = c >= "0" && c <= "9";
   assign pos_inc  = pos_ff + 1'b1;
   assign col_inc  = (col_ff != '1) ? col_ff + 1'b1 : col_ff;
   assign line_inc = (line_ff != '1) ? line_ff + 1'b1 : line_ff;

   // keyword match
   always_comb begin
      word_kind = KIND_IDENT;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
         kw_hit[k] = 1'b1;
         for (int j = 0; j < KEYWORD_LEN; j++) begin
            if (buf_ff[j] != KEYWORD_TABLE[k][j]) begin
               kw_hit[k] = 1'b0;
            end
         end
      end
      if (wlen_ff == WLEN_W'(KEYWORD_LEN)) begin
         for (int k = 0; k < KEYWORD_COUNT; k++) begin
            if (kw_hit[k]) begin
               word_kind = KEYWORD_KIND[k];
            end
         end
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      begin_in  = begin_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      wlen_in   = wlen_ff;
      buf_in    = buf_ff;
      run_idle  = 1'b0;
      flush     = 1'b0;
      idle_emit = 1'b0;
      str_close = 1'b0;
      flush_tok = '0;
      idle_tok  = '0;

      flush_tok.start  = begin_ff;
      flush_tok.length = pos_ff - begin_ff;
      flush_tok.line   = line_ff;
      flush_tok.column = col_ff;

      unique case (mode_ff)
         MODE_WORD: begin
            if (is_alpha || is_digit) begin
               if (wlen_ff < WLEN_W'(KEYWORD_MAX)) begin
                  buf_in[wlen_ff[BUF_IDX_W-1:0]] = c;
               end
               if (wlen_ff <= WLEN_W'(KEYWORD_MAX)) begin
                  wlen_in = wlen_ff + 1'b1;
               end
               pos_in = pos_inc;
               col_in = col_inc;
            end else begin
               flush          = 1'b1;
               flush_tok.kind = word_kind;
               run_idle       = 1'b1;
            end
         end
         MODE_INT: begin
            if (is_digit) begin
               pos_in = pos_inc;
               col_in = col_inc;
            end else if (c == CHAR_DOT) begin
               pos_in  = pos_inc;
               col_in  = col_inc;
               mode_in = MODE_FRAC;
            end else begin
               flush          = 1'b1;
               flush_tok.kind = KIND_NUMBER;
               run_idle       = 1'b1;
            end
         end
         MODE_FRAC: begin
            if (is_digit) begin
               pos_in = pos_inc;
               col_in = col_inc;
            end else begin
               flush          = 1'b1;
               flush_tok.kind = KIND_NUMBER;
               run_idle       = 1'b1;
            end
         end
         MODE_STR: begin
            if (c == CHAR_QUOTE) begin
               pos_in           = pos_inc;
               col_in           = col_inc;
               mode_in          = MODE_IDLE;
               str_close        = 1'b1;
               flush_tok.kind   = KIND_STRING;
               flush_tok.length = pos_inc - begin_ff;
               flush_tok.column = col_inc;
            end else if (c == CHAR_NUL) begin
               flush          = 1'b1;
               flush_tok.kind = KIND_UNTERM;
               run_idle       = 1'b1;
            end else begin
               pos_in = pos_inc;
               col_in = col_inc;
            end
         end
         default: begin
            run_idle = 1'b1;
         end
      endcase

      if (run_idle) begin
         mode_in         = MODE_IDLE;
         idle_tok.start  = pos_ff;
         idle_tok.length = POSITION_WIDTH'(1);
         idle_tok.line   = line_ff;
         idle_tok.column = col_inc;
         unique case (c) inside
            CHAR_NUL: begin
               idle_emit       = 1'b1;
               idle_tok.kind   = KIND_END;
               idle_tok.length = '0;
               idle_tok.column = col_ff;
               pos_in          = '0;
               begin_in        = '0;
               line_in         = LINE_WIDTH'(1);
               col_in          = LINE_WIDTH'(1);
               wlen_in         = '0;
            end
            CHAR_LF: begin
               line_in = line_inc;
               col_in  = LINE_WIDTH'(1);
               pos_in  = pos_inc;
            end
            CHAR_SPACE, CHAR_TAB, CHAR_CR: begin
               pos_in = pos_inc;
               col_in = col_inc;
            end
            default: begin
               begin_in = pos_ff;
               pos_in   = pos_inc;
               col_in   = col_inc;
               if (is_alpha) begin
                  buf_in[0] = c;
                  wlen_in   = WLEN_W'(1);
                  mode_in   = MODE_WORD;
               end else if (is_digit) begin
                  mode_in = MODE_INT;
               end else if (c == CHAR_QUOTE) begin
                  mode_in = MODE_STR;
               end else begin
                  idle_emit = 1'b1;
                  unique case (c)
                     CHAR_LPAREN:    idle_tok.kind = KIND_LPAREN;
                     CHAR_RPAREN:    idle_tok.kind = KIND_RPAREN;
                     CHAR_LBRACE:    idle_tok.kind = KIND_LBRACE;
                     CHAR_RBRACE:    idle_tok.kind = KIND_RBRACE;
                     CHAR_COMMA:     idle_tok.kind = KIND_COMMA;
                     CHAR_SEMICOLON: idle_tok.kind = KIND_SEMICOLON;
                     CHAR_DOT:       idle_tok.kind = KIND_DOT;
                     default:        idle_tok.kind = KIND_UNEXPECT;
                  endcase
               end
            end
         endcase
      end
   end

   assign q_push         = accept && (flush || str_close || idle_emit);
   assign q_entry.pair   = flush && idle_emit;
   assign q_entry.first  = (flush || str_close) ? flush_tok : idle_tok;
   assign q_entry.second = idle_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         begin_ff <= '0;
         line_ff  <= LINE_WIDTH'(1);
         col_ff   <= LINE_WIDTH'(1);
         wlen_ff  <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         wlen_ff  <= wlen_in;
         buf_ff   <= buf_in;
      end
   end

endmodule

// ----- design/sts_queue.sv -----
// ----------------------------------------------------------------------------
// sts_queue
// small fifo of token entries between the scanner front and the output side
// ----------------------------------------------------------------------------
module sts_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_push,
   input  sts_pkg::entry_type        q_entry,
   input  logic                      q_pop,
   output sts_pkg::entry_type        q_head,
   output sts_pkg::queue_status_type q_status
);
   import sts_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign q_status.full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign q_head         = slot_ff[rd_ff];
   assign do_push        = q_push && !q_status.full;
   assign do_pop         = q_pop && !q_status.empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
         if (do_push) begin
            slot_ff[wr_ff] <= q_entry;
         end
      end
   end

endmodule

// ----- design/sts_back.sv -----
// ----------------------------------------------------------------------------
// sts_back
// unpacks queue entries into single token transactions on a registered output
// ----------------------------------------------------------------------------
module sts_back (
   input  logic                      clock,
   input  logic                      reset,
   input  sts_pkg::entry_type        q_head,
   input  sts_pkg::queue_status_type q_status,
   output logic                      q_pop,
   sts_rsp_if.source                 rsp_bus
);
   import sts_pkg::*;

   logic      valid_ff, valid_in;
   logic      second_ff, second_in;
   logic      last_ff, last_in;
   token_type tok_ff, tok_in;
   logic      load;

   assign load = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      last_in   = last_ff;
      tok_in    = tok_ff;
      q_pop     = 1'b0;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            tok_in    = second_ff ? q_head.second : q_head.first;
            last_in   = !q_head.pair || second_ff;
            q_pop     = !q_head.pair || second_ff;
            second_in = q_head.pair && !second_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
      last_ff <= last_in;
      tok_ff  <= tok_in;
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.token_kind   = tok_ff.kind;
   assign rsp_bus.token_start  = tok_ff.start;
   assign rsp_bus.token_length = tok_ff.length;
   assign rsp_bus.token_line   = tok_ff.line;
   assign rsp_bus.token_column = tok_ff.column;
   assign rsp_bus.last_of_run  = last_ff;

endmodule

// ----- design/source_token_scanner.sv -----
// a completed token is written into the queue, then registered in sts_back for rsp_bus
// throughput: one source byte per cycle unless the queue is full, one token per cycle
// while rsp_bus is ready; a two-token byte fills one entry of the four-entry queue
// reset: synchronous, returns to offset 0, line 1, column 1 and empties the queue
// ----------------------------------------------------------------------------
// source_token_scanner
// streaming lexical scanner: source bytes in, token transactions out
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module source_token_scanner (
   input  logic      clock,
   input  logic      reset,
   sts_req_if.sink   req_bus,
   sts_rsp_if.source rsp_bus
);
   import sts_pkg::*;

   logic             q_push;
   logic             q_pop;
   entry_type        q_entry;
   entry_type        q_head;
   queue_status_type q_status;

   sts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_status (q_status),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   sts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_entry  (q_entry),
      .q_pop    (q_pop),
      .q_head   (q_head),
      .q_status (q_status)
   );

   sts_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp_bus  (rsp_bus)
   );

   `ASSERT_NEVER(a_push_when_full, clock, reset, q_push && q_status.full)
   `ASSERT_NEVER(a_pop_when_empty, clock, reset, q_pop && q_status.empty)
   `ASSERT_PROP(a_idle_after_reset, clock, 1'b0, reset |=> !rsp_bus.valid)

endmodule
